### src/knn_pkg.sv
package knn_pkg;

	// Widths of the fixed request and result fields.
	localparam int MODE_BITS     = 2;
	localparam int COORD_IN_BITS = 16;
	localparam int IDX_OUT_BITS  = 10;
	localparam int DIST_OUT_BITS = 33;

	// Request modes.
	localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

	// Control broadcast to every cell of the neighbor chain.
	typedef struct packed {
		logic clear;
		logic load;
		logic shift;
	} chain_ctrl_t;

endpackage

### src/knn_ram.sv
module knn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/knn_dist.sv
module knn_dist #(
	parameter int CB = 16,
	parameter int IW = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pt_valid,
	input  logic [IW-1:0]        pt_idx,
	input  logic [CB-1:0]        pt_x,
	input  logic [CB-1:0]        pt_y,
	input  logic [CB-1:0]        q_x,
	input  logic [CB-1:0]        q_y,
	output logic                 cand_valid,
	output logic [IW-1:0]        cand_idx,
	output logic [2*CB:0]        cand_dist,
	output logic                 busy
);

	logic [CB:0]     dx_diff, dy_diff;
	logic [CB-1:0]   dx_abs, dy_abs;
	logic            v_s2, v_s3, v_s4;
	logic [IW-1:0]   idx_s2, idx_s3, idx_s4;
	logic [CB-1:0]   dx_s2, dy_s2;
	logic [2*CB-1:0] dxx_s3, dyy_s3;
	logic [2*CB:0]   dist_s4;

	// Absolute coordinate differences; they always fit in CB bits.
	always_comb begin
		dx_diff = {pt_x[CB-1], pt_x} - {q_x[CB-1], q_x};
		dy_diff = {pt_y[CB-1], pt_y} - {q_y[CB-1], q_y};
		dx_abs  = dx_diff[CB] ? CB'(~dx_diff + 1'b1) : dx_diff[CB-1:0];
		dy_abs  = dy_diff[CB] ? CB'(~dy_diff + 1'b1) : dy_diff[CB-1:0];
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= pt_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Difference, square and sum stages.
	always_ff @(posedge clk) begin
		idx_s2  <= pt_idx;
		dx_s2   <= dx_abs;
		dy_s2   <= dy_abs;
		idx_s3  <= idx_s2;
		dxx_s3  <= dx_s2 * dx_s2;
		dyy_s3  <= dy_s2 * dy_s2;
		idx_s4  <= idx_s3;
		dist_s4 <= {1'b0, dxx_s3} + {1'b0, dyy_s3};
	end

	assign cand_valid = v_s4;
	assign cand_idx   = idx_s4;
	assign cand_dist  = dist_s4;
	assign busy       = v_s2 | v_s3 | v_s4;

endmodule

### src/knn_cell.sv
module knn_cell #(
	parameter int DW = 33,
	parameter int IW = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  knn_pkg::chain_ctrl_t ctrl,
	input  logic [DW-1:0]        cand_dist,
	input  logic [IW-1:0]        cand_idx,
	input  logic                 prev_ins,
	input  logic                 prev_valid,
	input  logic [DW-1:0]        prev_dist,
	input  logic [IW-1:0]        prev_idx,
	input  logic                 next_valid,
	input  logic [DW-1:0]        next_dist,
	input  logic [IW-1:0]        next_idx,
	output logic                 valid,
	output logic [DW-1:0]        entry_dist,
	output logic [IW-1:0]        idx,
	output logic                 ins
);

	import knn_pkg::*;

	logic          valid_q;
	logic [DW-1:0] dist_q;
	logic [IW-1:0] idx_q;

	// The candidate goes in front of this entry when it is strictly closer or the entry is empty.
	// Equal distances keep the older, lower index first.
	assign ins = ctrl.load && (!valid_q || (cand_dist < dist_q));

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ins) begin
			valid_q <= prev_ins ? prev_valid : 1'b1;
		end
	end

	// Entry payload: take the neighbor's entry or the candidate.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			dist_q <= next_dist;
			idx_q  <= next_idx;
		end else if (ins) begin
			dist_q <= prev_ins ? prev_dist : cand_dist;
			idx_q  <= prev_ins ? prev_idx : cand_idx;
		end
	end

	assign valid      = valid_q;
	assign entry_dist = dist_q;
	assign idx        = idx_q;

endmodule

### src/k_nearest_neighbor_select_core.sv
// K-nearest-neighbor selector over a store of 2D points. A load request
// appends one point to the store; loads into a full store are dropped,
// and a clear request empties the store.
// A query request names a stored vertex and returns up to NEIGHBORS
// results, nearest first by squared distance, ties to the lower index,
// the final one marked by last; a query of a vertex not stored, or with no
// other point stored, returns one result with found low. In a query,
// the single read port of the point store delivers one point per cycle
// to the distance pipeline, whose results are sorted on the fly by a
// chain of NEIGHBORS cells. Requests stall from the acceptance of a
// query until its last result has entered the output register.
module k_nearest_neighbor_select_core #(
	parameter int MAX_POINTS = 1024,
	parameter int NEIGHBORS  = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [knn_pkg::MODE_BITS-1:0]        mode,
	input  logic signed [knn_pkg::COORD_IN_BITS-1:0] x_coord,
	input  logic signed [knn_pkg::COORD_IN_BITS-1:0] y_coord,
	input  logic [knn_pkg::IDX_OUT_BITS-1:0]     query_vertex,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [knn_pkg::IDX_OUT_BITS-1:0]     neighbor_index,
	output logic [knn_pkg::DIST_OUT_BITS-1:0]    dist_sq,
	output logic                                 found,
	output logic                                 last
);

	import knn_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int QW = (CW > IDX_OUT_BITS) ? CW : IDX_OUT_BITS;
	localparam int DW = 2 * CB + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_QADDR  = 3'd1;
	localparam logic [2:0] ST_QLATCH = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_FLUSH  = 3'd4;
	localparam logic [2:0] ST_DRAIN  = 3'd5;

	logic [2:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   qidx_q;
	logic [IW-1:0]   scan_idx_q;
	logic [CB-1:0]   qx_q, qy_q;
	logic [CB-1:0]   x_c, y_c;
	logic            req_acc;
	logic            do_load, do_query, bad_query;
	logic            ram_we;
	logic [IW-1:0]   ram_raddr;
	logic [2*CB-1:0] ram_rdata;
	logic            rd_v_s1;
	logic [IW-1:0]   rd_idx_s1;
	logic            cand_valid;
	logic [IW-1:0]   cand_idx;
	logic [DW-1:0]   cand_dist;
	logic            dist_busy;
	logic            scan_end;
	chain_ctrl_t     ctrl;
	logic            emit, head_v, res_last;
	logic            c_valid [NEIGHBORS+2];
	logic [DW-1:0]   c_dist  [NEIGHBORS+2];
	logic [IW-1:0]   c_idx   [NEIGHBORS+2];
	logic            c_ins   [NEIGHBORS+1];
	logic            out_valid_q;
	logic [IDX_OUT_BITS-1:0]  nidx_q;
	logic [DIST_OUT_BITS-1:0] dist_q;
	logic            found_q, last_q;

	// Bring the input coordinates to COORD_BITS bits, sign in the top bit.
	if (COORD_BITS <= COORD_IN_BITS) begin : g_coord_narrow
		assign x_c = x_coord[CB-1:0];
		assign y_c = y_coord[CB-1:0];
	end else begin : g_coord_wide
		assign x_c = CB'(x_coord);
		assign y_c = CB'(y_coord);
	end

	// Request decode.
	assign in_stall  = (state_q != ST_IDLE);
	assign req_acc   = in_valid && !in_stall;
	assign do_load   = req_acc && (mode == MODE_LOAD);
	assign do_query  = req_acc && (mode == MODE_QUERY);
	assign bad_query = QW'(query_vertex) >= QW'(count_q);
	assign ram_we    = do_load && (count_q < CW'(MAX_POINTS));
	assign ram_raddr = (state_q == ST_QADDR) ? qidx_q : scan_idx_q;
	assign scan_end  = (CW'(scan_idx_q) + CW'(1)) == count_q;

	knn_ram #(
		.WIDTH(2 * CB),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata ({x_c, y_c}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: point count, query point fetch, scan, pipeline flush, result drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_v_s1    <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (ram_we) begin
						count_q <= count_q + CW'(1);
					end
					if (req_acc && (mode == MODE_CLEAR)) begin
						count_q <= '0;
					end
					if (do_query) begin
						scan_idx_q <= '0;
						state_q    <= bad_query ? ST_DRAIN : ST_QADDR;
					end
				end
				ST_QADDR: begin
					state_q <= ST_QLATCH;
				end
				ST_QLATCH: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_v_s1    <= (scan_idx_q != qidx_q);
					scan_idx_q <= scan_idx_q + IW'(1);
					if (scan_end) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!rd_v_s1 && !dist_busy) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (emit && res_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query vertex, query point and read tag.
	always_ff @(posedge clk) begin
		if (do_query) begin
			qidx_q <= IW'(query_vertex);
		end
		if (state_q == ST_QLATCH) begin
			qx_q <= ram_rdata[2*CB-1:CB];
			qy_q <= ram_rdata[CB-1:0];
		end
		rd_idx_s1 <= scan_idx_q;
	end

	knn_dist #(
		.CB(CB),
		.IW(IW)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (rd_v_s1),
		.pt_idx     (rd_idx_s1),
		.pt_x       (ram_rdata[2*CB-1:CB]),
		.pt_y       (ram_rdata[CB-1:0]),
		.q_x        (qx_q),
		.q_y        (qy_q),
		.cand_valid (cand_valid),
		.cand_idx   (cand_idx),
		.cand_dist  (cand_dist),
		.busy       (dist_busy)
	);

	// Chain control and drain handshake.
	assign head_v     = c_valid[1];
	assign emit       = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall);
	assign res_last   = !head_v || !c_valid[2];
	assign ctrl.clear = do_query;
	assign ctrl.load  = cand_valid;
	assign ctrl.shift = emit && head_v;

	// Empty entries stand before the first cell and after the last one.
	assign c_valid[0]           = 1'b0;
	assign c_dist[0]            = '0;
	assign c_idx[0]             = '0;
	assign c_ins[0]             = 1'b0;
	assign c_valid[NEIGHBORS+1] = 1'b0;
	assign c_dist[NEIGHBORS+1]  = '0;
	assign c_idx[NEIGHBORS+1]   = '0;

	for (genvar k = 0; k < NEIGHBORS; k++) begin : g_cell
		knn_cell #(
			.DW(DW),
			.IW(IW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.cand_dist  (cand_dist),
			.cand_idx   (cand_idx),
			.prev_ins   (c_ins[k]),
			.prev_valid (c_valid[k]),
			.prev_dist  (c_dist[k]),
			.prev_idx   (c_idx[k]),
			.next_valid (c_valid[k+2]),
			.next_dist  (c_dist[k+2]),
			.next_idx   (c_idx[k+2]),
			.valid      (c_valid[k+1]),
			.entry_dist (c_dist[k+1]),
			.idx        (c_idx[k+1]),
			.ins        (c_ins[k+1])
		);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			nidx_q  <= head_v ? IDX_OUT_BITS'(c_idx[1]) : '0;
			dist_q  <= head_v ? DIST_OUT_BITS'(c_dist[1]) : '0;
			found_q <= head_v;
			last_q  <= res_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign neighbor_index = nidx_q;
	assign dist_sq        = dist_q;
	assign found          = found_q;
	assign last           = last_q;

`ifndef SYNTHESIS
	// A candidate that goes before the first entry goes before every entry.
	a_ins_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		c_ins[1] |-> c_ins[NEIGHBORS])
		else $error("insert flags of the chain are not monotone");

	// The first two entries of the chain stay sorted by distance.
	a_chain_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(c_valid[1] && c_valid[2]) |-> !(c_dist[2] < c_dist[1]))
		else $error("neighbor chain out of order");

	// No distance is in flight once the block is idle.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!cand_valid && !rd_v_s1))
		else $error("candidate in flight while idle");

	// A result without a neighbor always closes its query.
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> last)
		else $error("empty result not marked last");

	// The point count never passes the store size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond store size");
`endif

endmodule

### tb/tb_k_nearest_neighbor_select_core.sv
module tb_k_nearest_neighbor_select_core;
	timeunit 1ns;
	timeprecision 1ps;

	import knn_pkg::*;

	localparam int MAX_POINTS = 1024;
	localparam int NEIGHBORS  = 8;
	localparam int COORD_BITS = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_PER_PHASE = 44;

	// Mode 3 has no meaning in the block and must be ignored.
	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

	typedef enum int {
		PH_STEADY,
		PH_SENDER_GAPS,
		PH_RECEIVER_STALLS,
		PH_BOTH
	} idle_phase_t;

	typedef struct packed {
		logic [MODE_BITS-1:0]            mode;
		logic signed [COORD_IN_BITS-1:0] x;
		logic signed [COORD_IN_BITS-1:0] y;
		logic [IDX_OUT_BITS-1:0]         vertex;
	} request_t;

	typedef struct packed {
		logic [IDX_OUT_BITS-1:0]  index;
		logic [DIST_OUT_BITS-1:0] distance;
		logic                     found;
		logic                     last;
	} neighbor_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_BITS-1:0] mode = MODE_LOAD;
	logic signed [COORD_IN_BITS-1:0] x_coord = '0;
	logic signed [COORD_IN_BITS-1:0] y_coord = '0;
	logic [IDX_OUT_BITS-1:0] query_vertex = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [IDX_OUT_BITS-1:0] neighbor_index;
	logic [DIST_OUT_BITS-1:0] dist_sq;
	logic found;
	logic last;

	idle_phase_t phase = PH_STEADY;
	request_t pending_requests[$];
	request_t next_request;
	neighbor_t expected_neighbors[$];
	neighbor_t seen;
	neighbor_t want;
	int error_count = 0;
	int cycle_count = 0;

	// Shadow copy of the point store used for prediction.
	logic signed [COORD_IN_BITS-1:0] store_x[MAX_POINTS];
	logic signed [COORD_IN_BITS-1:0] store_y[MAX_POINTS];
	int stored_count = 0;

	// Point count as seen by the stimulus generator, to aim queries.
	int planned_count = 0;

	k_nearest_neighbor_select_core #(
		.MAX_POINTS(MAX_POINTS),
		.NEIGHBORS (NEIGHBORS),
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.query_vertex  (query_vertex),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.neighbor_index(neighbor_index),
		.dist_sq       (dist_sq),
		.found         (found),
		.last          (last)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Apply one accepted request to the shadow store and queue the neighbors it yields.
	task automatic predict_neighbors(input request_t req);
		int n;
		int p;
		int i;
		int best_index[NEIGHBORS];
		longint best_dist[NEIGHBORS];
		longint dx;
		longint dy;
		longint d;
		neighbor_t r;
		case (req.mode)
			MODE_LOAD: begin
				if (stored_count < MAX_POINTS) begin
					store_x[stored_count] = req.x;
					store_y[stored_count] = req.y;
					stored_count++;
				end
			end
			MODE_CLEAR: begin
				stored_count = 0;
			end
			MODE_QUERY: begin
				n = 0;
				if (int'(req.vertex) < stored_count) begin
					for (i = 0; i < stored_count; i++) begin
						if (i == int'(req.vertex))
							continue;
						dx = longint'(store_x[i]) - longint'(store_x[req.vertex]);
						dy = longint'(store_y[i]) - longint'(store_y[req.vertex]);
						d = dx * dx + dy * dy;
						if (n < NEIGHBORS) begin
							p = n;
							n++;
						end else if (d < best_dist[NEIGHBORS-1]) begin
							p = NEIGHBORS - 1;
						end else begin
							continue;
						end
						// Strict compare keeps the lower index ahead on equal distance.
						while (p > 0 && best_dist[p-1] > d) begin
							best_dist[p] = best_dist[p-1];
							best_index[p] = best_index[p-1];
							p--;
						end
						best_dist[p] = d;
						best_index[p] = i;
					end
				end
				if (n == 0) begin
					r = '{index: '0, distance: '0, found: 1'b0, last: 1'b1};
					expected_neighbors.push_back(r);
				end
				for (i = 0; i < n; i++) begin
					r.index = best_index[i][IDX_OUT_BITS-1:0];
					r.distance = best_dist[i][DIST_OUT_BITS-1:0];
					r.found = 1'b1;
					r.last = (i == n - 1);
					expected_neighbors.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	function automatic int sender_gap_pct();
		case (phase)
			PH_SENDER_GAPS: return 45;
			PH_BOTH: return 8;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (phase)
			PH_RECEIVER_STALLS: return 45;
			PH_BOTH: return 8;
			default: return 0;
		endcase
	endfunction

	// Coordinates mostly from a tiny range so that equal distances are common.
	function automatic logic signed [COORD_IN_BITS-1:0] pick_coord();
		if ($urandom_range(2) == 0)
			return COORD_IN_BITS'($urandom());
		return COORD_IN_BITS'($signed($urandom_range(8)) - 4);
	endfunction

	task automatic queue_request(input logic [MODE_BITS-1:0] m,
			input logic signed [COORD_IN_BITS-1:0] xc,
			input logic signed [COORD_IN_BITS-1:0] yc,
			input logic [IDX_OUT_BITS-1:0] vertex);
		pending_requests.push_back('{mode: m, x: xc, y: yc, vertex: vertex});
		if (m == MODE_LOAD && planned_count < MAX_POINTS)
			planned_count++;
		else if (m == MODE_CLEAR)
			planned_count = 0;
	endtask

	task automatic wait_queue_empty();
		while (pending_requests.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	// Request driver: holds a stalled request, otherwise presents the next one or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_LOAD;
			x_coord <= '0;
			y_coord <= '0;
			query_vertex <= '0;
		end else begin
			if (in_valid && !in_stall)
				predict_neighbors('{mode: mode, x: x_coord, y: y_coord, vertex: query_vertex});
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
					next_request = pending_requests.pop_front();
					in_valid <= 1'b1;
					mode <= next_request.mode;
					x_coord <= next_request.x;
					y_coord <= next_request.y;
					query_vertex <= next_request.vertex;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{index: neighbor_index, distance: dist_sq, found: found, last: last};
				if (expected_neighbors.size() == 0) begin
					report_mismatch($sformatf("unexpected result index=%0d dist=%0d found=%0b last=%0b",
						seen.index, seen.distance, seen.found, seen.last));
				end else begin
					want = expected_neighbors.pop_front();
					if (seen.index !== want.index)
						report_mismatch($sformatf("neighbor_index %0d, expected %0d",
							seen.index, want.index));
					if (seen.distance !== want.distance)
						report_mismatch($sformatf("dist_sq %0d, expected %0d",
							seen.distance, want.distance));
					if (seen.found !== want.found)
						report_mismatch($sformatf("found %0b, expected %0b", seen.found, want.found));
					if (seen.last !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b", seen.last, want.last));
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct());
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("** k_nearest_neighbor_select_core: FAILED **");
			$finish;
		end
	end

	initial begin
		int j;
		int r;
		logic [IDX_OUT_BITS-1:0] vertex;

		// Directed requests: empty store, lone point, coordinate extremes, ties, truncation.
		queue_request(MODE_QUERY, '0, '0, '0);
		queue_request(MODE_UNUSED, 16'sh7FFF, -16'sh8000, '1);
		queue_request(MODE_LOAD, -16'sh8000, -16'sh8000, '0);
		queue_request(MODE_QUERY, '0, '0, '0);
		queue_request(MODE_LOAD, 16'sh7FFF, 16'sh7FFF, '0);
		queue_request(MODE_QUERY, '0, '0, 10'd0);
		queue_request(MODE_QUERY, '0, '0, 10'd1);
		queue_request(MODE_QUERY, '0, '0, 10'd2);
		queue_request(MODE_QUERY, '0, '0, '1);
		queue_request(MODE_LOAD, 16'sd0, 16'sd0, '0);
		queue_request(MODE_LOAD, 16'sd1, 16'sd0, '0);
		queue_request(MODE_LOAD, 16'sd0, 16'sd1, '0);
		queue_request(MODE_LOAD, -16'sd1, 16'sd0, '0);
		queue_request(MODE_LOAD, 16'sd0, -16'sd1, '0);
		queue_request(MODE_LOAD, 16'sd1, 16'sd1, '0);
		queue_request(MODE_LOAD, -16'sd1, -16'sd1, '0);
		queue_request(MODE_LOAD, 16'sd2, 16'sd0, '0);
		queue_request(MODE_LOAD, 16'sd0, 16'sd2, '0);
		queue_request(MODE_QUERY, '0, '0, 10'd2);
		queue_request(MODE_QUERY, '0, '0, 10'd10);
		queue_request(MODE_UNUSED, '0, '0, 10'd3);
		queue_request(MODE_CLEAR, 16'sh5555, -16'sh5556, 10'h2AA);
		queue_request(MODE_QUERY, '0, '0, 10'd0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Random requests, one share per idling phase: mostly loads and queries.
		for (int ph = PH_STEADY; ph <= PH_BOTH; ph++) begin
			wait_queue_empty();
			phase = idle_phase_t'(ph);
			j = 0;
			while (j < RANDOM_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 50) begin
					queue_request(MODE_LOAD, pick_coord(), pick_coord(),
						IDX_OUT_BITS'($urandom()));
					j++;
				end else if (r < 88) begin
					if ($urandom_range(4) != 0)
						vertex = IDX_OUT_BITS'($urandom_range(planned_count));
					else
						vertex = IDX_OUT_BITS'($urandom());
					queue_request(MODE_QUERY, COORD_IN_BITS'($urandom()),
						COORD_IN_BITS'($urandom()), vertex);
					j++;
				end else if (r < 94) begin
					queue_request(MODE_CLEAR, COORD_IN_BITS'($urandom()),
						COORD_IN_BITS'($urandom()), IDX_OUT_BITS'($urandom()));
					j++;
				end else begin
					queue_request(MODE_UNUSED, COORD_IN_BITS'($urandom()),
						COORD_IN_BITS'($urandom()), IDX_OUT_BITS'($urandom()));
				end
			end
		end

		wait_queue_empty();
		while (expected_neighbors.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("** k_nearest_neighbor_select_core: PASSED **");
		else
			$display("** k_nearest_neighbor_select_core: FAILED **");
		$finish;
	end

endmodule
